// ----- sv/fsde_pkg.sv -----
package fsde_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  localparam int XW = $clog2(MAX_WIDTH);       // raw x
  localparam int YW = $clog2(MAX_HEIGHT);      // raw y
  localparam int AW = $clog2(DEPTH);           // store address
  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width, span counts
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int NW = $clog2(DEPTH + 1);       // words written per item
  localparam int CW = 11;                      // config data width
  localparam int PW = 16;                      // pixel width
  localparam int SW = 18;                      // signed span arithmetic

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_FILL  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_SWAP  = 3'd5;

  localparam logic [1:0] CFG_ROTATION = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;

  localparam logic [10:0] RESET_WIDTH  = 11'd800;
  localparam logic [9:0]  RESET_HEIGHT = 10'd480;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [PW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [PW-1:0] read_color;
    logic [NW-1:0] pixels_written;
  } result_t;

  function automatic logic [PW-1:0] swap_bytes(input logic [PW-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

// ----- sv/fsde_store.sv -----
module fsde_store import fsde_pkg::*; (
  input  logic          clk,
  input  mem_req_t      req,
  output logic [PW-1:0] rdata
);

  logic [PW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- sv/fsde_seq.sv -----
module fsde_seq import fsde_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           op,
  input  logic signed [15:0]   x_coord,
  input  logic signed [15:0]   y_coord,
  input  logic signed [15:0]   span_length,
  input  logic [PW-1:0]        pixel_color,
  input  logic [1:0]           rotation,
  input  logic [10:0]          panel_width,
  input  logic [9:0]           panel_height,
  output logic                 res_valid,
  input  logic                 res_ready,
  output result_t              res,
  output mem_req_t             mem_req,
  input  logic [PW-1:0]        rdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NORM, S_CLIP, S_START, S_ADDR, S_LINE,
    S_RD_ISSUE, S_RD_DATA, S_FILL, S_SWAP, S_SWAP_LAST, S_FINISH
  } state_t;

  state_t               state;
  logic [2:0]           op_q;
  logic                 horiz;
  logic signed [SW-1:0] s, o, ln;
  logic [PW-1:0]        color;
  logic [XW-1:0]        rx;
  logic [YW-1:0]        ry;
  logic [AW-1:0]        addr, step, wptr;
  logic                 wvalid;
  logic [WW-1:0]        cnt;
  logic [PW-1:0]        rd;
  logic [NW-1:0]        n;

  logic [WW-1:0]        w_eff, lw, lh, smax, omax, w_m1, h_m1, xs, ys, rx_c, ry_c;
  logic [HW-1:0]        h_eff;
  logic signed [SW-1:0] smax_s, omax_s, s_end;
  logic [NW-1:0]        total_c, addr_calc;
  logic [AW-1:0]        addr_sum, step_c;
  logic [1:0]           dir;

  // clamp panel size to the store
  always_comb begin
    if (panel_width == '0) begin
      w_eff = WW'(1);
    end else if (panel_width > 11'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(panel_width);
    end
    if (panel_height == '0) begin
      h_eff = HW'(1);
    end else if (panel_height > 10'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(panel_height);
    end
  end

  assign lw      = rotation[0] ? WW'(h_eff) : w_eff;
  assign lh      = rotation[0] ? w_eff : WW'(h_eff);
  assign smax    = horiz ? lw : lh;
  assign omax    = horiz ? lh : lw;
  assign smax_s  = $signed({{(SW-WW){1'b0}}, smax});
  assign omax_s  = $signed({{(SW-WW){1'b0}}, omax});
  assign s_end   = s + ln;
  assign total_c = NW'(w_eff) * NW'(h_eff);

  // shared stepping adder: walks every loop over the store
  assign addr_sum = addr + ((state == S_LINE) ? step : AW'(1));

  // logical start point to raw position
  assign xs   = horiz ? s[WW-1:0] : o[WW-1:0];
  assign ys   = horiz ? o[WW-1:0] : s[WW-1:0];
  assign w_m1 = w_eff - WW'(1);
  assign h_m1 = WW'(h_eff) - WW'(1);

  always_comb begin
    unique case (rotation)
      2'd1: begin
        rx_c = w_m1 - ys;
        ry_c = xs;
      end
      2'd2: begin
        rx_c = w_m1 - xs;
        ry_c = h_m1 - ys;
      end
      2'd3: begin
        rx_c = ys;
        ry_c = h_m1 - xs;
      end
      default: begin
        rx_c = xs;
        ry_c = ys;
      end
    endcase
  end

  assign addr_calc = NW'(ry) * NW'(w_eff) + NW'(rx);

  // raw address step per span pixel: +1, +W, -1, -W as the span turns
  assign dir = horiz ? rotation : rotation + 2'd1;
  always_comb begin
    unique case (dir)
      2'd1:    step_c = AW'(w_eff);
      2'd2:    step_c = '1;
      2'd3:    step_c = AW'(0) - AW'(w_eff);
      default: step_c = AW'(1);
    endcase
  end

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = addr;
    mem_req.wdata = color;
    mem_req.raddr = addr;
    unique case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = '0;
      end
      S_LINE, S_FILL: mem_req.we = 1'b1;
      S_SWAP: begin
        mem_req.we    = wvalid;
        mem_req.waddr = wptr;
        mem_req.wdata = swap_bytes(rdata);
      end
      S_SWAP_LAST: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wptr;
        mem_req.wdata = swap_bytes(rdata);
      end
      default: ;
    endcase
  end

  assign in_ready           = (state == S_IDLE);
  assign res_valid          = (state == S_FINISH);
  assign res.read_color     = rd;
  assign res.pixels_written = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      addr   <= '0;
      wvalid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          addr <= addr_sum;
          if (addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= op;
            color  <= pixel_color;
            rd     <= '0;
            n      <= '0;
            addr   <= '0;
            wvalid <= 1'b0;
            horiz  <= (op != OP_VLINE);
            if (op == OP_VLINE) begin
              s <= SW'(y_coord);
              o <= SW'(x_coord);
            end else begin
              s <= SW'(x_coord);
              o <= SW'(y_coord);
            end
            // single-pixel ops run as a span of one
            if (op == OP_HLINE || op == OP_VLINE) begin
              ln <= SW'(span_length);
            end else begin
              ln <= SW'(1);
            end
            unique case (op) inside
              OP_PIXEL, OP_HLINE, OP_VLINE, OP_READ: state <= S_NORM;
              OP_FILL: begin
                n     <= total_c;
                state <= S_FILL;
              end
              OP_SWAP: begin
                n     <= total_c;
                state <= S_SWAP;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_NORM: begin
          // negative length: same span ending at the start point
          if (ln < 0) begin
            s  <= s_end + SW'(1);
            ln <= -ln;
          end
          state <= S_CLIP;
        end
        S_CLIP: begin
          if (o < 0 || o >= omax_s || s >= smax_s || s_end < SW'(1)) begin
            state <= S_FINISH;
          end else begin
            if (s < 0) begin
              ln <= s_end;
              s  <= '0;
            end
            state <= S_START;
          end
        end
        S_START: begin
          if (s_end > smax_s) begin
            ln <= smax_s - s;
          end
          rx    <= rx_c[XW-1:0];
          ry    <= ry_c[YW-1:0];
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr <= addr_calc[AW-1:0];
          step <= step_c;
          cnt  <= ln[WW-1:0];
          if (op_q == OP_READ) begin
            state <= S_RD_ISSUE;
          end else if (ln == '0) begin
            state <= S_FINISH;
          end else begin
            n     <= NW'(ln[WW-1:0]);
            state <= S_LINE;
          end
        end
        S_LINE: begin
          addr <= addr_sum;
          cnt  <= cnt - WW'(1);
          if (cnt == WW'(1)) begin
            state <= S_FINISH;
          end
        end
        S_RD_ISSUE: state <= S_RD_DATA;
        S_RD_DATA: begin
          rd    <= rdata;
          state <= S_FINISH;
        end
        S_FILL: begin
          addr <= addr_sum;
          if (NW'(addr) + NW'(1) == n) begin
            state <= S_FINISH;
          end
        end
        S_SWAP: begin
          // read one word ahead of the write-back
          wptr   <= addr;
          wvalid <= 1'b1;
          addr   <= addr_sum;
          if (NW'(addr) + NW'(1) == n) begin
            state <= S_SWAP_LAST;
          end
        end
        S_SWAP_LAST: state <= S_FINISH;
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/framebuffer_span_draw_engine.sv -----
// RGB565 framebuffer engine: one command per item, one result item per command.
// After reset the store is swept to zero, one word a cycle, before the first
// item is taken. Pixel ops and lines pass through the normalise, clip, start and
// address states; a pixel read then issues its read and takes the data, and a
// line writes one pixel per cycle after clipping. A shape rejected as wholly
// off the canvas goes from the clip state straight to the result. Fill and
// byte swap step one word per cycle, set by the single write port of the frame
// store, which one stepping adder walks. The result passes through an output
// register, and the sequencer returns to idle before the next item is taken.
// Configuration writes are taken at any time but must only be made while idle.
module framebuffer_span_draw_engine import fsde_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          op,
  input  logic signed [15:0]  x_coord,
  input  logic signed [15:0]  y_coord,
  input  logic signed [15:0]  span_length,
  input  logic [15:0]         pixel_color,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         read_color,
  output logic [19:0]         pixels_written,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CW-1:0]       cfg_data
);

  logic [1:0]    rotation;
  logic [10:0]   panel_width;
  logic [9:0]    panel_height;
  logic          res_valid, res_ready;
  result_t       res;
  mem_req_t      mem_req;
  logic [PW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation     <= '0;
      panel_width  <= RESET_WIDTH;
      panel_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROTATION: rotation     <= cfg_data[1:0];
        CFG_WIDTH:    panel_width  <= cfg_data[10:0];
        CFG_HEIGHT:   panel_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  fsde_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .span_length  (span_length),
    .pixel_color  (pixel_color),
    .rotation     (rotation),
    .panel_width  (panel_width),
    .panel_height (panel_height),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_req      (mem_req),
    .rdata        (rdata)
  );

  fsde_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // output register: the next item may start while this result waits
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      read_color     <= res.read_color;
      pixels_written <= res.pixels_written;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted an item on consecutive cycles");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mem_req.we)
    else $error("store written while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixels_written <= NW'(DEPTH))
    else $error("written count beyond store depth");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while output register full");

endmodule

// ----- test/tb_framebuffer_span_draw_engine.sv -----
module tb_framebuffer_span_draw_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import fsde_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int QUIET_LIMIT = 2_000_000;  // covers the clearing sweep after reset
  localparam int FILL_AREA_CAP = 2048;     // fill and swap only on small panels
  localparam int PHASE_ITEMS = 104;

  typedef enum logic [1:0] {ROT_0, ROT_90, ROT_180, ROT_270} rot_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] op = OP_PIXEL;
  logic signed [15:0] x_coord = '0;
  logic signed [15:0] y_coord = '0;
  logic signed [15:0] span_length = '0;
  logic [15:0] pixel_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] read_color;
  logic [19:0] pixels_written;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_ROTATION;
  logic [CW-1:0] cfg_data = '0;

  framebuffer_span_draw_engine u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .span_length(span_length),
    .pixel_color(pixel_color),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_color(read_color),
    .pixels_written(pixels_written),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the frame store and panel registers
  bit [15:0] frame_mirror [DEPTH];
  rot_e panel_rot = ROT_0;
  int panel_w_reg = 800;
  int panel_h_reg = 480;

  result_t draw_outcomes_q[$];
  bit idling_on = 1'b1;
  int mismatch_count = 0;
  int results_seen = 0;
  int settings_used = 1;
  int op_count [8];
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic int eff_width();
    int w;
    w = panel_w_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = panel_h_reg;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int logical_width();
    return panel_rot[0] ? eff_height() : eff_width();
  endfunction

  function automatic int logical_height();
    return panel_rot[0] ? eff_width() : eff_height();
  endfunction

  function automatic bit raw_addr(input int x, input int y, output int addr);
    int w, h, rx, ry;
    w = eff_width();
    h = eff_height();
    case (panel_rot)
      ROT_90: begin
        rx = w - 1 - y;
        ry = x;
      end
      ROT_180: begin
        rx = w - 1 - x;
        ry = h - 1 - y;
      end
      ROT_270: begin
        rx = y;
        ry = h - 1 - x;
      end
      default: begin
        rx = x;
        ry = y;
      end
    endcase
    addr = 0;
    if (rx < 0 || ry < 0 || rx >= w || ry >= h) return 1'b0;
    addr = ry * w + rx;
    return 1'b1;
  endfunction

  function automatic int draw_span(input bit horiz, input int x, input int y, input int len,
                                   input logic [15:0] colour);
    int s, o, smax, omax, n, a, px, py;
    s = horiz ? x : y;
    o = horiz ? y : x;
    smax = horiz ? logical_width() : logical_height();
    omax = horiz ? logical_height() : logical_width();
    n = 0;
    // negative length: same span run backwards from the start point
    if (len < 0) begin
      len = -len;
      s -= len - 1;
      if (s < 0) begin
        len += s;
        s = 0;
      end
    end
    if (o < 0 || o >= omax || s >= smax || s + len - 1 < 0) return 0;
    if (s < 0) begin
      len += s;
      s = 0;
    end
    if (s + len > smax) len = smax - s;
    for (int i = 0; i < len; i++) begin
      px = horiz ? s + i : o;
      py = horiz ? o : s + i;
      if (raw_addr(px, py, a)) begin
        frame_mirror[a] = colour;
        n++;
      end
    end
    return n;
  endfunction

  function automatic result_t apply_draw_cmd(input logic [2:0] cmd_op, input int x, input int y,
                                             input int len, input logic [15:0] colour);
    result_t r;
    int a, total;
    logic [15:0] v;
    r = '0;
    total = eff_width() * eff_height();
    case (cmd_op)
      OP_PIXEL: begin
        if (raw_addr(x, y, a)) begin
          frame_mirror[a] = colour;
          r.pixels_written = NW'(1);
        end
      end
      OP_HLINE: r.pixels_written = NW'(draw_span(1'b1, x, y, len, colour));
      OP_VLINE: r.pixels_written = NW'(draw_span(1'b0, x, y, len, colour));
      OP_FILL: begin
        for (int i = 0; i < total; i++) frame_mirror[i] = colour;
        r.pixels_written = NW'(total);
      end
      OP_READ: begin
        if (raw_addr(x, y, a)) r.read_color = frame_mirror[a];
      end
      OP_SWAP: begin
        for (int i = 0; i < total; i++) begin
          v = frame_mirror[i];
          frame_mirror[i] = {v[7:0], v[15:8]};
        end
        r.pixels_written = NW'(total);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic send_cmd(input logic [2:0] cmd_op, input logic signed [15:0] x,
                          input logic signed [15:0] y, input logic signed [15:0] len,
                          input logic [15:0] colour);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= cmd_op;
    x_coord <= x;
    y_coord <= y;
    span_length <= len;
    pixel_color <= colour;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    draw_outcomes_q.push_back(apply_draw_cmd(cmd_op, x, y, len, colour));
    op_count[cmd_op]++;
  endtask

  // drop valid and wait for every owed result; block is then idle
  task automatic drain();
    in_valid <= 1'b0;
    while (draw_outcomes_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // write all three registers; unused upper data bits carry junk
  task automatic set_panel(input rot_e rot, input int width_val, input int height_val);
    logic [CW-1:0] rot_data, h_data;
    rot_data = {9'($urandom_range(0, 511)), rot};
    h_data = {1'($urandom_range(0, 1)), 10'(height_val)};
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROTATION;
    cfg_data <= rot_data;
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data <= CW'(width_val);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= h_data;
    @(posedge clk);
    cfg_write <= 1'b0;
    panel_rot = rot_e'(rot_data[1:0]);
    panel_w_reg = int'(width_val[10:0]);
    panel_h_reg = int'(h_data[9:0]);
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(input int lim);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 3))
          0: return -16'sd1;
          1: return 16'd0;
          2: return 16'(lim - 1);
          default: return 16'(lim);
        endcase
      end
      default: return 16'(int'($urandom_range(0, lim + 3)) - 2);
    endcase
  endfunction

  function automatic logic [15:0] rand_len(input int lim);
    int m;
    m = (lim < 64) ? lim + 2 : 64;
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'd0;
          3: return -16'sd1;
          default: return 16'd1;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 2 * m)) - m);
    endcase
  endfunction

  // reset panel 800x480, no rotation; store still cleared
  task automatic test_reset_geometry();
    send_cmd(OP_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'hffff);
    send_cmd(OP_PIXEL, 16'sd799, 16'sd479, 16'sd0, 16'h1234);
    send_cmd(OP_PIXEL, 16'sd800, 16'sd0, 16'sd0, 16'h5555);
    send_cmd(OP_PIXEL, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'haaaa);
    send_cmd(OP_READ, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
    send_cmd(OP_READ, 16'sd799, 16'sd479, 16'sd0, 16'h0000);
    send_cmd(OP_READ, -16'sd1, 16'sd5, 16'sd0, 16'h0000);
    send_cmd(OP_READ, 16'sd10, 16'sd10, 16'sd0, 16'h0000);
    send_cmd(OP_HLINE, 16'sd10, 16'sd10, 16'sd0, 16'h00ff);
    send_cmd(OP_HLINE, 16'sd5, 16'sd20, -16'sd8, 16'h0f0f);
    send_cmd(OP_HLINE, 16'sd790, 16'sd30, 16'sh7fff, 16'hf00f);
    send_cmd(OP_HLINE, 16'sd700, 16'sd40, 16'sh8000, 16'h8001);
    send_cmd(OP_VLINE, 16'sd3, 16'sd470, 16'sd20, 16'h7ffe);
    send_cmd(OP_VLINE, 16'sd900, 16'sd0, 16'sd5, 16'h1111);
    send_cmd(OP_SPARE6, 16'sd1, 16'sd1, 16'sd1, 16'h2222);
    send_cmd(OP_SPARE7, 16'sd2, 16'sd2, 16'sd2, 16'h3333);
    drain();
  endtask

  task automatic test_fill_and_swap();
    set_panel(ROT_0, 16, 8);
    send_cmd(OP_FILL, 16'sd0, 16'sd0, 16'sd0, 16'ha55a);
    send_cmd(OP_READ, 16'sd3, 16'sd2, 16'sd0, 16'h0000);
    send_cmd(OP_PIXEL, 16'sd15, 16'sd7, 16'sd0, 16'h00ff);
    send_cmd(OP_SWAP, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
    send_cmd(OP_READ, 16'sd15, 16'sd7, 16'sd0, 16'h0000);
    send_cmd(OP_READ, 16'sd3, 16'sd2, 16'sd0, 16'h0000);
    drain();
  endtask

  task automatic test_rotations();
    for (int r = 1; r < 4; r++) begin
      set_panel(rot_e'(r), 12, 7);
      send_cmd(OP_PIXEL, 16'sd1, 16'sd2, 16'sd0, 16'(16'hc000 + r));
      send_cmd(OP_READ, 16'sd1, 16'sd2, 16'sd0, 16'h0000);
      drain();
    end
  endtask

  task automatic test_random_traffic();
    logic [2:0] cmd_op;
    int k, lw, lh;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: set_panel(ROT_0, 0, 0);
        1: set_panel(ROT_90, 2047, 1023);
        2: set_panel(ROT_180, 1, 512);
        3: set_panel(ROT_270, 1024, 1);
        4: set_panel(ROT_90, 800, 480);
        default: set_panel(rot_e'($urandom_range(0, 3)), $urandom_range(1, 48),
                           $urandom_range(1, 40));
      endcase
      idling_on = (p < 10);
      lw = logical_width();
      lh = logical_height();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        k = $urandom_range(0, 99);
        if (k < 24) cmd_op = OP_PIXEL;
        else if (k < 44) cmd_op = OP_HLINE;
        else if (k < 64) cmd_op = OP_VLINE;
        else if (k < 88) cmd_op = OP_READ;
        else if (k < 92) cmd_op = OP_FILL;
        else if (k < 96) cmd_op = OP_SWAP;
        else cmd_op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        if ((cmd_op == OP_FILL || cmd_op == OP_SWAP) && eff_width() * eff_height() > FILL_AREA_CAP)
          cmd_op = OP_READ;
        send_cmd(cmd_op, rand_coord(lw), rand_coord(lh), rand_len(cmd_op == OP_VLINE ? lh : lw),
                 16'($urandom_range(0, 65535)));
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (draw_outcomes_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: colour %h count %0d",
                                read_color, pixels_written));
      end else begin
        want = draw_outcomes_q.pop_front();
        if (read_color !== want.read_color)
          flag_mismatch($sformatf("result %0d read_color %h, expected %h",
                                  results_seen, read_color, want.read_color));
        if (pixels_written !== want.pixels_written)
          flag_mismatch($sformatf("result %0d pixels_written %0d, expected %0d",
                                  results_seen, pixels_written, want.pixels_written));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, draw_outcomes_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_geometry();
    test_fill_and_swap();
    test_rotations();
    test_random_traffic();
    repeat (200) @(posedge clk);
    $display("Drew %0d pixels, %0d hlines, %0d vlines, %0d fills, %0d swaps, %0d spare ops",
             op_count[OP_PIXEL], op_count[OP_HLINE], op_count[OP_VLINE], op_count[OP_FILL],
             op_count[OP_SWAP], op_count[OP_SPARE6] + op_count[OP_SPARE7]);
    $display("Read back %0d pixels over %0d panel settings; %0d results checked, %0d mismatches",
             op_count[OP_READ], settings_used, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
